>>> design/wifi_tx_rate_adaptation_assert.svh
// Assertion macros used by the rate adaptation checker.
`ifndef WIFI_TX_RATE_ADAPTATION_ASSERT_SVH
`define WIFI_TX_RATE_ADAPTATION_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define WTRA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rate adaptation check failed");

// Next-cycle implication, quiet while reset is high.
`define WTRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rate adaptation check failed");

`endif

>>> design/wtra_pkg.sv
// Types, codes and reset constants of the transmit rate adaptation block.
`default_nettype none

package wtra_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_COMPLETE = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_RESTART  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_NUM_RATES       = 2'd0;
  localparam logic [1:0] REG_RAISE_PERCENT   = 2'd1;
  localparam logic [1:0] REG_RAISE_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_START_RATE      = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // Register reset values.
  localparam logic [4:0] RST_NUM_RATES       = 5'd8;
  localparam logic [6:0] RST_RAISE_PERCENT   = 7'd10;
  localparam logic [7:0] RST_RAISE_THRESHOLD = 8'd10;
  localparam logic [3:0] RST_START_RATE      = 4'd0;

  // Minimum delivered plus failed frames for a full evaluation.
  localparam int unsigned MIN_SAMPLES_DEFAULT = 10;

  // Retry limit is a percentage of deliveries.
  localparam logic [22:0] PERCENT_SCALE = 23'd100;

  typedef struct packed {
    logic [1:0] cmd;
    logic       tx_failed;
    logic [3:0] short_retries;
    logic [3:0] long_retries;
  } item_t;

  typedef struct packed {
    logic [3:0] rate_index;
    logic       rate_raised;
    logic       rate_dropped;
    logic [7:0] raise_credits;
  } result_t;

  typedef struct packed {
    logic [4:0] num_rates;
    logic [6:0] raise_percent;
    logic [7:0] raise_threshold;
    logic [3:0] start_rate;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  current_rate;
    logic [15:0] good_count;
    logic [15:0] fail_count;
    logic [15:0] retry_total;
    logic [7:0]  credit_count;
  } link_state_t;

endpackage

`default_nettype wire

>>> design/wtra_decide.sv
// Next-state and result logic for one item of the rate adaptation block.
`default_nettype none

module wtra_decide #(
  parameter int unsigned MIN_SAMPLES = wtra_pkg::MIN_SAMPLES_DEFAULT
) (
  input  wtra_pkg::link_state_t st,
  input  wtra_pkg::cfg_t        cfg,
  input  wtra_pkg::item_t       item,
  output wtra_pkg::link_state_t st_next,
  output wtra_pkg::result_t     res
);

  logic [3:0]  top_rate;
  logic [16:0] good_inc;
  logic [16:0] fail_inc;
  logic [16:0] retry_sum;
  logic [16:0] samples;
  logic        enough;
  logic [22:0] scaled_good;
  logic [22:0] retry_limit;
  logic        vote_down;
  logic        vote_up;
  logic [7:0]  credit_inc;
  logic [7:0]  credit_new;
  logic [3:0]  nrate;
  logic        raised;
  logic        dropped;

  // Highest usable index: a count of zero acts as one, above sixteen as sixteen.
  always_comb begin
    if (cfg.num_rates == 5'd0) begin
      top_rate = 4'd0;
    end else if (cfg.num_rates > 5'd16) begin
      top_rate = 4'd15;
    end else begin
      top_rate = 4'(cfg.num_rates - 5'd1);
    end
  end

  assign good_inc  = {1'b0, st.good_count} + 17'd1;
  assign fail_inc  = {1'b0, st.fail_count} + 17'd1;
  assign retry_sum = {1'b0, st.retry_total} + 17'(item.short_retries)
                   + 17'(item.long_retries);
  assign samples   = {1'b0, st.good_count} + {1'b0, st.fail_count};
  assign enough    = samples >= 17'(MIN_SAMPLES);

  // retry < floor(good * pct / 100) holds exactly when (retry + 1) * 100 <= good * pct.
  assign scaled_good = 23'(st.good_count) * 23'(cfg.raise_percent);
  assign retry_limit = (23'(st.retry_total) + 23'd1) * wtra_pkg::PERCENT_SCALE;

  assign vote_down = ((st.fail_count != 16'd0) && (st.good_count == 16'd0))
                   || (enough && (st.good_count < st.retry_total));
  assign vote_up   = enough && (st.fail_count == 16'd0) && (scaled_good >= retry_limit);

  assign credit_inc = (st.credit_count == 8'hFF) ? 8'hFF : st.credit_count + 8'd1;

  // Evaluation tick: an up vote overrides a down vote.
  always_comb begin
    nrate      = st.current_rate;
    credit_new = st.credit_count;
    priority if (vote_up) begin
      credit_new = credit_inc;
      if (credit_inc >= cfg.raise_threshold) begin
        credit_new = 8'd0;
        if (st.current_rate < top_rate) begin
          nrate = st.current_rate + 4'd1;
        end
      end
    end else if (vote_down) begin
      if (st.current_rate != 4'd0) begin
        nrate = st.current_rate - 4'd1;
      end
      credit_new = 8'd0;
    end else begin
      if (enough && (st.credit_count != 8'd0)) begin
        credit_new = st.credit_count - 8'd1;
      end
    end
  end

  always_comb begin
    st_next = st;
    raised  = 1'b0;
    dropped = 1'b0;
    unique case (item.cmd)
      wtra_pkg::CMD_COMPLETE: begin
        if (item.tx_failed) begin
          st_next.fail_count = fail_inc[16] ? 16'hFFFF : fail_inc[15:0];
        end else begin
          st_next.good_count = good_inc[16] ? 16'hFFFF : good_inc[15:0];
        end
        st_next.retry_total = retry_sum[16] ? 16'hFFFF : retry_sum[15:0];
      end
      wtra_pkg::CMD_TICK: begin
        st_next.credit_count = credit_new;
        if (nrate != st.current_rate) begin
          raised               = nrate > st.current_rate;
          dropped              = nrate < st.current_rate;
          st_next.current_rate = nrate;
          st_next.good_count   = 16'd0;
          st_next.fail_count   = 16'd0;
          st_next.retry_total  = 16'd0;
          st_next.credit_count = 8'd0;
        end else if (enough) begin
          st_next.good_count  = 16'd0;
          st_next.fail_count  = 16'd0;
          st_next.retry_total = 16'd0;
        end
      end
      wtra_pkg::CMD_RESTART: begin
        st_next.current_rate = (cfg.start_rate > top_rate) ? top_rate : cfg.start_rate;
        st_next.good_count   = 16'd0;
        st_next.fail_count   = 16'd0;
        st_next.retry_total  = 16'd0;
        st_next.credit_count = 8'd0;
      end
      default: begin
        // Unused command leaves the state alone.
      end
    endcase
  end

  assign res.rate_index    = st_next.current_rate;
  assign res.rate_raised   = raised;
  assign res.rate_dropped  = dropped;
  assign res.raise_credits = st_next.credit_count;

endmodule

`default_nettype wire

>>> design/wifi_tx_rate_adaptation.sv
// Top level of the single-link transmit rate adaptation block.
//
//   Channel   Direction  Handshake                    Payload
//   item      in         item_valid / item_stall      wtra_pkg::item_t
//   result    out        result_valid / result_stall  wtra_pkg::result_t
//   cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
// One item is accepted per cycle while item_stall is low. It waits in the input register
// while the decision logic works on it, and its result is then loaded into the result
// register, from which the result is offered.
// Reset (synchronous, rst high) empties both registers, clears the counters and
// credits and loads the register reset values, so the rate index is 0.
// A stalled result holds its register and, with the input register full, item_stall rises.
`default_nettype none

module wifi_tx_rate_adaptation #(
  parameter int unsigned MIN_SAMPLES = wtra_pkg::MIN_SAMPLES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  wtra_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output wtra_pkg::result_t                   result,
  input  logic                                cfg_we,
  input  logic [wtra_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wtra_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  wtra_pkg::cfg_t        cfg;

  // Link state: current index, saturating counters and raise credits.
  wtra_pkg::link_state_t st;
  wtra_pkg::link_state_t st_next;

  // Input register.
  logic                  hold_valid;
  wtra_pkg::item_t       hold_item;

  wtra_pkg::result_t     res_next;
  logic                  out_free;
  logic                  advance;

  // The result register can load when it is empty or its transfer happens now.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && out_free;
  assign item_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rates       <= wtra_pkg::RST_NUM_RATES;
      cfg.raise_percent   <= wtra_pkg::RST_RAISE_PERCENT;
      cfg.raise_threshold <= wtra_pkg::RST_RAISE_THRESHOLD;
      cfg.start_rate      <= wtra_pkg::RST_START_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wtra_pkg::REG_NUM_RATES:       cfg.num_rates       <= cfg_data[4:0];
        wtra_pkg::REG_RAISE_PERCENT:   cfg.raise_percent   <= cfg_data[6:0];
        wtra_pkg::REG_RAISE_THRESHOLD: cfg.raise_threshold <= cfg_data[7:0];
        wtra_pkg::REG_START_RATE:      cfg.start_rate      <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // The input register takes a new item whenever it is empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold_item <= item;
    end
  end

  wtra_decide #(
    .MIN_SAMPLES(MIN_SAMPLES)
  ) u_decide (
    .st      (st),
    .cfg     (cfg),
    .item    (hold_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // The state moves on exactly when an item passes into the result register,
  // so the next item in the input register always sees the updated state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.current_rate <= wtra_pkg::RST_START_RATE;
      st.good_count   <= 16'd0;
      st.fail_count   <= 16'd0;
      st.retry_total  <= 16'd0;
      st.credit_count <= 8'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> design/wtra_checker.sv
// Port-level checker for the rate adaptation block, bound to its top level.
`default_nettype none

`include "wifi_tx_rate_adaptation_assert.svh"

module wtra_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire wtra_pkg::result_t result
);

  // A stalled result stays offered and unchanged.
  `WTRA_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

  // One tick never moves the index both ways.
  `WTRA_ASSERT_NOW(a_one_direction, clk, rst, result_valid, !(result.rate_raised && result.rate_dropped))

  // A rate change clears the raise credits.
  `WTRA_ASSERT_NOW(a_raise_clears, clk, rst, result_valid && result.rate_raised, result.raise_credits == 8'd0)

  `WTRA_ASSERT_NOW(a_drop_clears, clk, rst, result_valid && result.rate_dropped, result.raise_credits == 8'd0)

endmodule

bind wifi_tx_rate_adaptation wtra_checker u_wtra_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
